@@ rtl/tls_pkg.sv @@
// shared types, codes and constants of the token lexer stream
package tls_pkg;

	// default width of the byte position and run length counters
	localparam int POSITION_BITS_DEF = 16;

	// width of the position and length fields of a result
	localparam int OUT_POS_W = 16;

	// result queue between the lexer core and the output port
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// keyword spelled by a letter run
	localparam int KW_LEN = 6;

	// bytes with a meaning of their own
	localparam logic [7:0] CH_EOT   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	typedef enum logic [3:0] {
		TK_ID         = 4'd0,
		TK_KW_PUBLIC  = 4'd1,
		TK_INT        = 4'd2,
		TK_EQUALS     = 4'd3,
		TK_LPAREN     = 4'd4,
		TK_RPAREN     = 4'd5,
		TK_LBRACE     = 4'd6,
		TK_RBRACE     = 4'd7,
		TK_COMMA      = 4'd8,
		TK_SEMICOLON  = 4'd9,
		TK_EOF        = 4'd10,
		TK_UNEXPECTED = 4'd11
	} token_kind_t;

	// kind of the open run, one-hot
	typedef enum logic [2:0] {
		RUN_NONE  = 3'b001,
		RUN_ALPHA = 3'b010,
		RUN_DIGIT = 3'b100
	} run_kind_t;

	// one result item
	typedef struct packed {
		token_kind_t            kind;
		logic [OUT_POS_W-1:0]   start;
		logic [OUT_POS_W-1:0]   len;
		logic [7:0]             chr;
		logic                   last;
	} token_t;

	// results caused by one byte, slot 0 first
	typedef struct packed {
		logic [1:0]       count;
		token_t [1:0]     tok;
	} lex_out_t;

	// letters of the keyword by index
	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h70;
			3'd1: ch = 8'h75;
			3'd2: ch = 8'h62;
			3'd3: ch = 8'h6C;
			3'd4: ch = 8'h69;
			3'd5: ch = 8'h63;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/tls_lexer_core.sv @@
// lexer core: run tracking state and the results of one byte
module tls_lexer_core import tls_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] char_code,
	output lex_out_t   res
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	run_kind_t                run_kind_q, run_kind_d;
	logic [POSITION_BITS-1:0] run_start_q, run_start_d;
	logic [POSITION_BITS-1:0] run_len_q, run_len_d;
	logic                     kw_match_q, kw_match_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;

	logic      is_alpha, is_digit, is_space, run_open, close_run, emit_single;
	run_kind_t cls;
	token_t    flush_tok, single_tok, eof_tok;
	token_kind_t single_kind;
	logic [POSITION_BITS-1:0] pos_inc, len_inc;
	logic      kw_hit;

	// position counter value shown on a 16-bit field
	function automatic logic [OUT_POS_W-1:0] to_out(input logic [POSITION_BITS-1:0] v);
		logic [POSITION_BITS+OUT_POS_W-1:0] w;
		w = {{OUT_POS_W{1'b0}}, v};
		return w[OUT_POS_W-1:0];
	endfunction

	// byte classes
	always_comb begin
		is_alpha = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
		is_digit = (char_code inside {[8'h30:8'h39]});
		is_space = (char_code inside {CH_CR, CH_LF, CH_SPACE, CH_TAB});
		if (is_alpha) begin
			cls = RUN_ALPHA;
		end else if (is_digit) begin
			cls = RUN_DIGIT;
		end else begin
			cls = RUN_NONE;
		end
		case (char_code)
			CH_EQ:    single_kind = TK_EQUALS;
			CH_LPAR:  single_kind = TK_LPAREN;
			CH_RPAR:  single_kind = TK_RPAREN;
			CH_LBRC:  single_kind = TK_LBRACE;
			CH_RBRC:  single_kind = TK_RBRACE;
			CH_COMMA: single_kind = TK_COMMA;
			CH_SEMI:  single_kind = TK_SEMICOLON;
			default:  single_kind = TK_UNEXPECTED;
		endcase
	end

	// saturating increments
	assign pos_inc = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
	assign len_inc = (run_len_q == POS_MAX) ? POS_MAX : run_len_q + 1'b1;

	// candidate tokens
	always_comb begin
		run_open = (run_kind_q != RUN_NONE);
		kw_hit = kw_match_q && (run_len_q == POSITION_BITS'(KW_LEN));

		flush_tok.kind  = (run_kind_q == RUN_ALPHA) ? (kw_hit ? TK_KW_PUBLIC : TK_ID) : TK_INT;
		flush_tok.start = to_out(run_start_q);
		flush_tok.len   = to_out(run_len_q);
		flush_tok.chr   = 8'd0;
		flush_tok.last  = 1'b0;

		single_tok.kind  = single_kind;
		single_tok.start = to_out(pos_q);
		single_tok.len   = OUT_POS_W'(1);
		single_tok.chr   = char_code;
		single_tok.last  = 1'b1;

		eof_tok.kind  = TK_EOF;
		eof_tok.start = to_out(pos_q);
		eof_tok.len   = '0;
		eof_tok.chr   = 8'd0;
		eof_tok.last  = 1'b1;
	end

	// results and next state for the byte at hand
	always_comb begin
		res         = '0;
		close_run   = run_open && (cls != run_kind_q);
		emit_single = (cls == RUN_NONE) && !is_space;
		run_kind_d  = run_kind_q;
		run_start_d = run_start_q;
		run_len_d   = run_len_q;
		kw_match_d  = kw_match_q;
		pos_d       = pos_inc;

		if (char_code == CH_EOT) begin
			// end of text: pending run, then the end token, then back to reset
			if (run_open) begin
				res.count  = 2'd2;
				res.tok[0] = flush_tok;
				res.tok[1] = eof_tok;
			end else begin
				res.count  = 2'd1;
				res.tok[0] = eof_tok;
			end
			run_kind_d  = RUN_NONE;
			run_start_d = '0;
			run_len_d   = '0;
			kw_match_d  = 1'b1;
			pos_d       = '0;
		end else begin
			// closing token of the open run comes first
			if (close_run) begin
				res.tok[0] = flush_tok;
				if (emit_single) begin
					res.count  = 2'd2;
					res.tok[1] = single_tok;
				end else begin
					res.count       = 2'd1;
					res.tok[0].last = 1'b1;
				end
				run_kind_d  = RUN_NONE;
				run_start_d = '0;
				run_len_d   = '0;
				kw_match_d  = 1'b1;
			end else if (emit_single) begin
				res.count  = 2'd1;
				res.tok[0] = single_tok;
			end

			// open or extend a run
			if (cls != RUN_NONE) begin
				if (!run_open || close_run) begin
					run_kind_d  = cls;
					run_start_d = pos_q;
					run_len_d   = POSITION_BITS'(1);
					kw_match_d  = (cls != RUN_ALPHA) || (char_code == kw_char(3'd0));
				end else begin
					run_len_d = len_inc;
					if (cls == RUN_ALPHA) begin
						kw_match_d = kw_match_q && (run_len_q < POSITION_BITS'(KW_LEN))
							&& (char_code == kw_char(run_len_q[2:0]));
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_kind_q  <= RUN_NONE;
			run_start_q <= '0;
			run_len_q   <= '0;
			kw_match_q  <= 1'b1;
			pos_q       <= '0;
		end else if (advance) begin
			run_kind_q  <= run_kind_d;
			run_start_q <= run_start_d;
			run_len_q   <= run_len_d;
			kw_match_q  <= kw_match_d;
			pos_q       <= pos_d;
		end
	end

	// end byte always closes with the end token
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && char_code == CH_EOT) |->
			((res.count == 2'd1 && res.tok[0].kind == TK_EOF)
			|| (res.count == 2'd2 && res.tok[1].kind == TK_EOF)))
		else $error("end byte without end token in final slot");

	// end byte returns the stream to its start
	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && char_code == CH_EOT) |=> (pos_q == '0 && run_kind_q == RUN_NONE))
		else $error("state not cleared after end byte");

	// last flag marks exactly the final result of a byte
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd2) |-> (!res.tok[0].last && res.tok[1].last))
		else $error("last flag misplaced on a two-result byte");

	a_last_one: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd1) |-> res.tok[0].last)
		else $error("last flag missing on a one-result byte");

endmodule

@@ rtl/tls_result_fifo.sv @@
// result queue: up to two writes per cycle, one read per cycle
module tls_result_fifo import tls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  lex_out_t wr,
	output logic     room,
	output logic     rd_valid,
	input  logic     rd_ready,
	output token_t   rd_tok
);

	token_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic [1:0]            n_wr;
	logic                  pop;

	assign n_wr     = wr_en ? wr.count : 2'd0;
	assign rd_valid = (count_q != '0);
	assign pop      = rd_valid && rd_ready;
	assign rd_tok   = mem_q[rd_ptr_q];
	// space for a byte that gives two results
	assign room     = (count_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2));

	// storage
	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.tok[0];
		end
		if (n_wr == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= wr.tok[1];
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_wr);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			count_q  <= count_q + (FIFO_PTR_W+1)'(n_wr) - (FIFO_PTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(n_wr != 2'd0) |-> room)
		else $error("results written without room");

endmodule

@@ rtl/token_lexer_stream.sv @@
// top level of the streaming lexical tokenizer
// One source byte per item; byte 0 ends the text, flushes any open run, gives the end
// token and clears the position. An item can be accepted every cycle while there is room:
// a byte is first held in an input register, then the lexer core classifies it, updates
// the run state and writes its zero, one or two results into a four-entry result queue,
// from which the output port reads them. Bytes that give at most one result stream at one
// per cycle while the output is ready; the output port delivers one result per cycle when
// out_ready is high, so a byte that closes a run and gives a token of its own yields two
// results. The input register moves on only when the queue has space for two results.
module token_lexer_stream import tls_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_code,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           token_kind,
	output logic [OUT_POS_W-1:0] start_pos,
	output logic [OUT_POS_W-1:0] token_len,
	output logic [7:0]           char_value,
	output logic                 last
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       advance;
	logic       room;
	lex_out_t   res;
	token_t     rd_tok;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	// classification and run tracking
	tls_lexer_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.char_code(char_s1),
		.res      (res)
	);

	// result queue feeding the output port
	tls_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance),
		.wr      (res),
		.room    (room),
		.rd_valid(out_valid),
		.rd_ready(out_ready),
		.rd_tok  (rd_tok)
	);

	// output fields
	assign token_kind = rd_tok.kind;
	assign start_pos  = rd_tok.start;
	assign token_len  = rd_tok.len;
	assign char_value = rd_tok.chr;
	assign last       = rd_tok.last;

endmodule

@@ test/token_lexer_stream_test.sv @@
// self-checking testbench of the streaming tokenizer: directed and random texts, checked per result
module token_lexer_stream_test import tls_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_W = POSITION_BITS_DEF;
	localparam logic [31:0] POS_SAT = (32'd1 << POS_W) - 32'd1;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_BYTES = 650;
	localparam logic [47:0] KW_TEXT = "public";
	localparam logic [7:0] PUNCT_SET [7] = '{CH_EQ, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC,
		CH_COMMA, CH_SEMI};
	localparam logic [7:0] BLANK_SET [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] token_kind;
	logic [OUT_POS_W-1:0] start_pos;
	logic [OUT_POS_W-1:0] token_len;
	logic [7:0] char_value;
	logic last;

	// source bytes waiting to be offered and tokens waiting to come out
	logic [7:0] src_q [$];
	token_t tok_expect [$];
	token_t burst [$];

	// tokenizer state as the predictor sees it
	run_kind_t run_st = RUN_NONE;
	logic [31:0] run_at = 32'd0;
	logic [31:0] run_cnt = 32'd0;
	logic [31:0] byte_at = 32'd0;
	logic kw_ok = 1'b1;

	int errs = 0;
	int sent_cnt = 0;
	int tok_cnt = 0;
	int text_cnt = 0;
	int cyc = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int kind_seen [12];

	token_lexer_stream DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.start_pos  (start_pos),
		.token_len  (token_len),
		.char_value (char_value),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// counters stop at all ones of the position width
	function automatic logic [31:0] sat_step(input logic [31:0] v);
		return (v >= POS_SAT) ? POS_SAT : v + 32'd1;
	endfunction

	function automatic token_t make_tok(input token_kind_t k, input logic [31:0] p,
		input logic [31:0] n, input logic [7:0] ch);
		token_t t;
		t.kind = k;
		t.start = p[OUT_POS_W-1:0];
		t.len = n[OUT_POS_W-1:0];
		t.chr = ch;
		t.last = 1'b0;
		return t;
	endfunction

	// emit the token of the open run, if any, and close it
	function automatic void close_run();
		if (run_st == RUN_ALPHA) begin
			burst.push_back(make_tok((kw_ok && run_cnt == KW_LEN) ? TK_KW_PUBLIC : TK_ID,
				run_at, run_cnt, 8'd0));
		end else if (run_st == RUN_DIGIT) begin
			burst.push_back(make_tok(TK_INT, run_at, run_cnt, 8'd0));
		end
		run_st = RUN_NONE;
		run_at = 32'd0;
		run_cnt = 32'd0;
		kw_ok = 1'b1;
	endfunction

	// tokens caused by one accepted byte
	function automatic void lex_byte(input logic [7:0] c);
		run_kind_t cls;
		token_kind_t pk;
		logic is_alpha;
		logic is_digit;
		is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		is_digit = (c >= "0" && c <= "9");
		cls = is_alpha ? RUN_ALPHA : (is_digit ? RUN_DIGIT : RUN_NONE);
		burst.delete();
		if (c == CH_EOT) begin
			close_run();
			burst.push_back(make_tok(TK_EOF, byte_at, 32'd0, 8'd0));
			byte_at = 32'd0;
		end else begin
			if (run_st != RUN_NONE && cls != run_st)
				close_run();
			if (cls != RUN_NONE) begin
				if (run_st == RUN_NONE) begin
					run_st = cls;
					run_at = byte_at;
					run_cnt = 32'd0;
					kw_ok = 1'b1;
				end
				if (is_alpha && (run_cnt >= KW_LEN || KW_TEXT[47 - 8 * run_cnt -: 8] != c))
					kw_ok = 1'b0;
				run_cnt = sat_step(run_cnt);
			end else if (c != CH_CR && c != CH_LF && c != CH_SPACE && c != CH_TAB) begin
				case (c)
					CH_EQ:    pk = TK_EQUALS;
					CH_LPAR:  pk = TK_LPAREN;
					CH_RPAR:  pk = TK_RPAREN;
					CH_LBRC:  pk = TK_LBRACE;
					CH_RBRC:  pk = TK_RBRACE;
					CH_COMMA: pk = TK_COMMA;
					CH_SEMI:  pk = TK_SEMICOLON;
					default:  pk = TK_UNEXPECTED;
				endcase
				burst.push_back(make_tok(pk, byte_at, 32'd1, c));
			end
			byte_at = sat_step(byte_at);
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			tok_expect.push_back(burst[i]);
	endfunction

	// stimulus helpers
	function automatic void put_str(input string s);
		foreach (s[i])
			src_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
			: 8'("A" + $urandom_range(0, 25));
	endfunction

	// one text of random lexemes, mostly closed by the end byte
	function automatic void add_text();
		int n_lex;
		int pick;
		int i;
		string w;
		n_lex = $urandom_range(1, 8);
		repeat (n_lex) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				repeat ($urandom_range(1, 8))
					src_q.push_back(rand_letter());
			end else if (pick < 32) begin
				// keyword and its near misses
				w = "public";
				case ($urandom_range(0, 3))
					0: put_str(w);
					1: begin
						put_str(w);
						src_q.push_back(rand_letter());
					end
					2: put_str(w.substr(0, $urandom_range(0, 4)));
					default: begin
						i = $urandom_range(0, 5);
						w[i] = w[i] ^ 8'h20;
						put_str(w);
					end
				endcase
			end else if (pick < 47) begin
				repeat ($urandom_range(1, 6))
					src_q.push_back(8'("0" + $urandom_range(0, 9)));
			end else if (pick < 67) begin
				src_q.push_back(PUNCT_SET[$urandom_range(0, 6)]);
			end else if (pick < 81) begin
				repeat ($urandom_range(1, 3))
					src_q.push_back(BLANK_SET[$urandom_range(0, 3)]);
			end else if (pick < 94) begin
				src_q.push_back(8'($urandom_range(1, 255)));
			end else begin
				src_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			src_q.push_back(CH_EOT);
			text_cnt++;
		end
	endfunction

	// sender: offer the next byte unless taking a break
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				lex_byte(char_code);
				sent_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (src_q.size() > 0 && ((sent_cnt >= 200 && sent_cnt < 330)
					|| $urandom_range(0, 99) >= 12)) begin
					in_valid <= 1'b1;
					char_code <= src_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each token, stall at random and once for a long stretch
	always @(posedge clk) begin : tok_check
		token_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (tok_expect.size() == 0) begin
					$error("token with none expected: kind %0d start %0d", token_kind, start_pos);
					errs++;
				end else begin
					want = tok_expect.pop_front();
					if (token_kind != want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						errs++;
					end
					if (start_pos != want.start) begin
						$error("start_pos: expected %0d, got %0d", want.start, start_pos);
						errs++;
					end
					if (token_len != want.len) begin
						$error("token_len: expected %0d, got %0d", want.len, token_len);
						errs++;
					end
					if (char_value != want.chr) begin
						$error("char_value: expected %0d, got %0d", want.chr, char_value);
						errs++;
					end
					if (last != want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						errs++;
					end
				end
				if (token_kind < 12)
					kind_seen[token_kind]++;
				tok_cnt++;
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && tok_cnt >= 100) begin
				hold_left <= 80;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (tok_cnt >= 150 && tok_cnt < 260) || $urandom_range(0, 99) >= 12;
			end
		end
	end

	// run time guard
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("token_lexer_stream_test failed");
			$finish;
		end
	end

	initial begin : run_main
		string kinds;
		int start_len;
		// directed text: keyword, prefix then digit, punctuation, blanks, odd bytes, run at end
		put_str("public=publi1,(){};");
		put_str(" \t\r\n");
		src_q.push_back(8'hFF);
		src_q.push_back(8'h01);
		put_str("Az9");
		src_q.push_back(CH_EOT);
		text_cnt++;
		start_len = src_q.size();
		while (src_q.size() < start_len + RANDOM_BYTES)
			add_text();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (src_q.size() != 0 || in_valid)
			@(posedge clk);
		while (tok_expect.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		kinds = "";
		foreach (kind_seen[k])
			kinds = {kinds, $sformatf(" %0d", kind_seen[k])};
		$display("%0d bytes in %0d texts, %0d tokens checked under stalls on both sides",
			sent_cnt, text_cnt, tok_cnt);
		$display("tokens per kind (id .. unexpected):%s", kinds);
		if (errs == 0) begin
			$display("token_lexer_stream_test passed");
		end else begin
			$display("token_lexer_stream_test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/tls_pkg.sv
rtl/tls_lexer_core.sv
rtl/tls_result_fifo.sv
rtl/token_lexer_stream.sv
test/token_lexer_stream_test.sv
